// ===== hw/rtl/oset_pkg.sv =====
// shared types and constants for the one-shot event timer table
// command, result and status codes plus the controller/datapath interface structs
// depends on nothing
`default_nettype none

package oset_pkg;

	// default sizing
	localparam int ENTRIES_DEF    = 16;
	localparam int ID_BITS_DEF    = 8;
	localparam int COUNT_BITS_DEF = 16;

	// fixed field widths
	localparam int CMD_W    = 2;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int FIRED_W  = 8;

	// input commands
	localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNSET  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_SET_ACK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UNSET_ACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

	// what the output register loads
	typedef enum logic [1:0] {
		EMIT_NONE     = 2'd0,
		EMIT_ACK      = 2'd1,
		EMIT_EXP_MID  = 2'd2,
		EMIT_EXP_LAST = 2'd3
	} emit_t;

	// controller to datapath
	typedef struct packed {
		logic  capture;
		logic  rd_en;
		logic  wr_tick;
		logic  wr_set;
		logic  wr_unset;
		logic  alloc;
		logic  hit_set;
		logic  pend_load;
		logic  pend_clear;
		emit_t emit;
	} dp_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             more;
		logic             match;
		logic             armed;
		logic             expire;
		logic             full;
		logic             hit;
		logic             pend_valid;
		logic             out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/one_shot_event_timer_table.sv =====
// top level of the one-shot event timer table
// joins the controller (oset_ctrl) and datapath (oset_dp); depends on oset_pkg
//
// usage:
// - input channel (in_valid/in_ready) takes one command transaction: cmd, event_id, duration.
//   set arms a timer for event_id, unset disarms it, tick advances every armed timer.
// - output channel (out_valid/out_ready) gives result transactions: kind, status,
//   fired_id and last. set and unset give exactly one result; a tick gives one result
//   per expired timer in slot order, last marking the final one; an unused command gives none.
// - one command at a time: in_ready is high only while the sequencer is idle.
//   the slot scan reads one slot per cycle through the single read port of the slot memory,
//   except while a tick waits for the output register; an unused command never leaves idle.
// - results leave through an output register, so the next command is taken while a
//   result still waits; a tick holds back one expiry until it knows whether it is the last.
// - when the receiver stalls, the scan pauses on the next expiry (or at the final
//   acknowledge or expiry) until the output register frees up; nothing is dropped.
// - reset (arst_n low) empties the table and the output register; the slot memory
//   itself is not cleared, slots beyond the used count are never read.
`default_nettype none

module one_shot_event_timer_table #(
	parameter int ENTRIES    = oset_pkg::ENTRIES_DEF,
	parameter int ID_BITS    = oset_pkg::ID_BITS_DEF,
	parameter int COUNT_BITS = oset_pkg::COUNT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// command channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [oset_pkg::CMD_W-1:0]     cmd,
	input  wire logic [ID_BITS-1:0]             event_id,
	input  wire logic [COUNT_BITS-1:0]          duration,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [oset_pkg::KIND_W-1:0]         kind,
	output logic [oset_pkg::STATUS_W-1:0]       status,
	output logic [oset_pkg::FIRED_W-1:0]        fired_id,
	output logic                                last
);

	// command and status between sequencer and datapath
	oset_pkg::dp_ctl_t ctl;
	oset_pkg::dp_sts_t sts;

	oset_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	oset_dp #(
		.ENTRIES    (ENTRIES),
		.ID_BITS    (ID_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.event_id  (event_id),
		.duration  (duration),
		.ctl       (ctl),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.kind      (kind),
		.status    (status),
		.fired_id  (fired_id),
		.last      (last)
	);

	// a real command keeps the block busy in the following cycle
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (cmd != oset_pkg::CMD_UNUSED)) |=> !in_ready)
		else $error("command accepted but block ready again at once");

	// at most one slot write per cycle
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.wr_tick, ctl.wr_set, ctl.wr_unset}))
		else $error("several slot writes in one cycle");

	// a result is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit != oset_pkg::EMIT_NONE) |-> sts.out_free)
		else $error("result overwrites one not yet taken");

	// a new slot is taken only while the table has room and the id is not already in it
	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.alloc |-> (!sts.full && !sts.hit))
		else $error("slot allocated on a full table or on a known id");

endmodule

`default_nettype wire

// ===== hw/rtl/oset_ctrl.sv =====
// sequencing state machine of the one-shot event timer table
// drives the datapath by command struct, watches its status struct
// depends on oset_pkg
`default_nettype none

module oset_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [oset_pkg::CMD_W-1:0] cmd,
	output logic                           in_ready,
	input  wire oset_pkg::dp_sts_t         sts,
	output oset_pkg::dp_ctl_t              ctl
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_EVAL = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		ctl       = '0;
		ctl.emit  = oset_pkg::EMIT_NONE;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					if (cmd != oset_pkg::CMD_UNUSED) begin
						state_nxt = S_RD;
					end
				end
			end
			S_RD: begin
				if (sts.more) begin
					ctl.rd_en = 1'b1;
					state_nxt = S_EVAL;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_EVAL: begin
				case (sts.cmd) inside
					oset_pkg::CMD_SET, oset_pkg::CMD_UNSET: begin
						// stop on the first match so the entry stays in the read register
						if (sts.match) begin
							ctl.hit_set = 1'b1;
							state_nxt   = S_DONE;
						end else if (sts.more) begin
							ctl.rd_en = 1'b1;
						end else begin
							state_nxt = S_DONE;
						end
					end
					oset_pkg::CMD_TICK: begin
						// hold while an older expiry cannot leave
						if (!(sts.armed && sts.expire && sts.pend_valid && !sts.out_free)) begin
							if (sts.armed) begin
								ctl.wr_tick = 1'b1;
								if (sts.expire) begin
									ctl.pend_load = 1'b1;
									if (sts.pend_valid) begin
										ctl.emit = oset_pkg::EMIT_EXP_MID;
									end
								end
							end
							if (sts.more) begin
								ctl.rd_en = 1'b1;
							end else begin
								state_nxt = S_DONE;
							end
						end
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_DONE: begin
				case (sts.cmd)
					oset_pkg::CMD_SET: begin
						if (sts.out_free) begin
							ctl.emit = oset_pkg::EMIT_ACK;
							if (sts.hit) begin
								ctl.wr_set = 1'b1;
							end else if (!sts.full) begin
								ctl.wr_set = 1'b1;
								ctl.alloc  = 1'b1;
							end
							state_nxt = S_IDLE;
						end
					end
					oset_pkg::CMD_UNSET: begin
						if (sts.out_free) begin
							ctl.emit     = oset_pkg::EMIT_ACK;
							ctl.wr_unset = sts.hit;
							state_nxt    = S_IDLE;
						end
					end
					oset_pkg::CMD_TICK: begin
						if (!sts.pend_valid) begin
							state_nxt = S_IDLE;
						end else if (sts.out_free) begin
							ctl.emit       = oset_pkg::EMIT_EXP_LAST;
							ctl.pend_clear = 1'b1;
							state_nxt      = S_IDLE;
						end
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/oset_dp.sv =====
// datapath of the one-shot event timer table: slot memory, scan index,
// pending expiry holder and output register
// depends on oset_pkg
`default_nettype none

module oset_dp #(
	parameter int ENTRIES    = oset_pkg::ENTRIES_DEF,
	parameter int ID_BITS    = oset_pkg::ID_BITS_DEF,
	parameter int COUNT_BITS = oset_pkg::COUNT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [oset_pkg::CMD_W-1:0]     cmd,
	input  wire logic [ID_BITS-1:0]             event_id,
	input  wire logic [COUNT_BITS-1:0]          duration,
	input  wire oset_pkg::dp_ctl_t              ctl,
	output oset_pkg::dp_sts_t                   sts,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [oset_pkg::KIND_W-1:0]         kind,
	output logic [oset_pkg::STATUS_W-1:0]       status,
	output logic [oset_pkg::FIRED_W-1:0]        fired_id,
	output logic                                last
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int WORD_W = ID_BITS + 2 * COUNT_BITS + 1;

	// slot word: id, count, limit, armed
	logic [WORD_W-1:0] mem [ENTRIES];
	logic [WORD_W-1:0] rdata_q;
	logic [IDX_W-1:0]  eidx_q;

	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  used_q;
	logic              hit_q;

	logic [oset_pkg::CMD_W-1:0] cmd_q;
	logic [ID_BITS-1:0]         id_q;
	logic [COUNT_BITS-1:0]      dur_q;

	logic               pend_valid_q;
	logic [ID_BITS-1:0] pend_id_q;

	logic                          out_valid_q;
	logic [oset_pkg::KIND_W-1:0]   kind_q;
	logic [oset_pkg::STATUS_W-1:0] status_q;
	logic [oset_pkg::FIRED_W-1:0]  fired_q;
	logic                          last_q;

	logic [ID_BITS-1:0]    r_id;
	logic [COUNT_BITS-1:0] r_count;
	logic [COUNT_BITS-1:0] r_limit;
	logic                  r_armed;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  expire;
	logic                  full;
	logic                  out_free;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;

	logic [ID_BITS+oset_pkg::FIRED_W-1:0] ack_ext;
	logic [ID_BITS+oset_pkg::FIRED_W-1:0] pend_ext;

	assign {r_id, r_count, r_limit, r_armed} = rdata_q;

	assign cnt_inc  = r_count + COUNT_BITS'(1);
	assign expire   = (cnt_inc == r_limit);
	assign full     = (used_q == CNT_W'(ENTRIES));
	assign out_free = !out_valid_q || out_ready;

	assign ack_ext  = {oset_pkg::FIRED_W'(0), id_q};
	assign pend_ext = {oset_pkg::FIRED_W'(0), pend_id_q};

	always_comb begin
		sts.cmd        = cmd_q;
		sts.more       = (idx_q < used_q);
		sts.match      = (r_id == id_q);
		sts.armed      = r_armed;
		sts.expire     = expire;
		sts.full       = full;
		sts.hit        = hit_q;
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

	// write-back selection
	always_comb begin
		wr_en   = ctl.wr_tick || ctl.wr_set || ctl.wr_unset;
		wr_addr = eidx_q;
		wr_data = {r_id, COUNT_BITS'(0), r_limit, 1'b0};
		if (ctl.wr_set) begin
			wr_data = {id_q, COUNT_BITS'(0), dur_q, 1'b1};
			if (!hit_q) begin
				wr_addr = used_q[IDX_W-1:0];
			end
		end else if (ctl.wr_tick) begin
			wr_data = {r_id, (expire ? COUNT_BITS'(0) : cnt_inc), r_limit, !expire};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[idx_q[IDX_W-1:0]];
			eidx_q  <= idx_q[IDX_W-1:0];
		end
		if (ctl.capture) begin
			cmd_q <= cmd;
			id_q  <= event_id;
			dur_q <= duration;
		end
		if (ctl.pend_load) begin
			pend_id_q <= r_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			used_q       <= '0;
			hit_q        <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (ctl.rd_en) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (ctl.hit_set) begin
					hit_q <= 1'b1;
				end
			end
			if (ctl.alloc) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (ctl.pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (ctl.pend_clear) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit != oset_pkg::EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.emit) inside
			oset_pkg::EMIT_ACK: begin
				last_q  <= 1'b1;
				fired_q <= ack_ext[oset_pkg::FIRED_W-1:0];
				if (cmd_q == oset_pkg::CMD_SET) begin
					kind_q   <= oset_pkg::KIND_SET_ACK;
					status_q <= (hit_q || !full) ? oset_pkg::STAT_OK : oset_pkg::STAT_FULL;
				end else begin
					kind_q   <= oset_pkg::KIND_UNSET_ACK;
					status_q <= hit_q ? oset_pkg::STAT_OK : oset_pkg::STAT_NOT_FOUND;
				end
			end
			oset_pkg::EMIT_EXP_MID, oset_pkg::EMIT_EXP_LAST: begin
				kind_q   <= oset_pkg::KIND_EXPIRED;
				status_q <= oset_pkg::STAT_OK;
				fired_q  <= pend_ext[oset_pkg::FIRED_W-1:0];
				last_q   <= (ctl.emit == oset_pkg::EMIT_EXP_LAST);
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign status    = status_q;
	assign fired_id  = fired_q;
	assign last      = last_q;

endmodule

`default_nettype wire
